### rtl/core/ultrasonic_echo_cluster_ranger_defines.svh
// Assertion macros for the ultrasonic echo cluster ranger.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef ULTRASONIC_ECHO_CLUSTER_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_CLUSTER_RANGER_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define UECR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define UECR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/uecr_pkg.sv
// Shared types and constants of the ultrasonic echo cluster ranger.
// No dependencies; used by every module of the block.
package uecr_pkg;

   localparam int READINGS_PER_POINT = 5;

   localparam int TICK_W     = 32;
   localparam int TIME_W     = 16;
   localparam int RANGE_W    = 16;
   localparam int SERVO_W    = 12;
   localparam int STEP_W     = 11;
   localparam int DIST_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int CNT_W      = $clog2(READINGS_PER_POINT + 1);
   localparam int IDX_W      = (READINGS_PER_POINT > 1) ? $clog2(READINGS_PER_POINT) : 1;
   localparam int SUM_W      = TIME_W + $clog2(READINGS_PER_POINT + 1);
   localparam int DIV_STEP_W = $clog2(SUM_W);
   localparam bit SINGLE_READING = (READINGS_PER_POINT <= 1);

   // 0.1715 mm per microsecond in 0.16 fixed point.
   localparam int SCALE_W     = 14;
   localparam logic [SCALE_W-1:0] RANGE_SCALE = 14'd11239;
   localparam int PROD_W      = TIME_W + SCALE_W;
   localparam int RANGE_SHIFT = 16;

   localparam int SERVO_CMP_W = SERVO_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - (1 + RANGE_W + SERVO_W + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLUSTER_DIST = 3'd0,
      CSR_FALLBACK     = 3'd1,
      CSR_PULSE_TOP    = 3'd2,
      CSR_PULSE_FLOOR  = 3'd3,
      CSR_SERVO_STEP   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIST_W-1:0]  cluster_dist;
      logic [RANGE_W-1:0] fallback;
      logic [SERVO_W-1:0] pulse_top;
      logic [SERVO_W-1:0] pulse_floor;
      logic [STEP_W-1:0]  servo_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      cluster_dist: 16'd292,
      fallback:     16'd3990,
      pulse_top:    12'd2500,
      pulse_floor:  12'd500,
      servo_step:   11'd11
   };

   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] data;
   } reading_push_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic               point;
      logic               done;
      logic [SERVO_W-1:0] servo;
      logic [RANGE_W-1:0] range;
      logic               trig;
   } rsp_type;

endpackage

### rtl/core/ultrasonic_echo_cluster_ranger.sv
// Channel | Direction | Handshake              | Payload
// req     | in        | req_tvalid/req_tready  | tuser: edge_level; tdata: edge_tick
// rsp     | out       | rsp_tvalid/rsp_tready  | tuser: point_valid; tdata: see port
// csr     | in        | csr_we (no wait)       | csr_index, csr_wdata
//
// A rising edge is taken and gives no result.
// A falling edge that does not close a group raises rsp_tvalid after
// passing the queue and the IDLE and EMIT states; one that closes a group
// goes through the scan, the bit-serial divider and one multiply, or only
// the scan when nothing clusters and the fallback range is sent.
// Reset is synchronous; the result register and queue let input and
// output stall independently.
`include "ultrasonic_echo_cluster_ranger_defines.svh"

module ultrasonic_echo_cluster_ranger (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,   // [0] edge_level
   input  logic [uecr_pkg::REQ_DATA_W-1:0]    req_tdata,   // [31:0] edge_tick
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_tuser,   // [0] point_valid
   // [0] trigger_next, [16:1] range_mm, [28:17] servo_pulse_us,
   // [29] sweep_done, [31:30] zero
   output logic [uecr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [uecr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [uecr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   uecr_pkg::cfg_type            cfg_ff, cfg_in;
   uecr_pkg::queue_status_type   q_status;
   uecr_pkg::reading_push_type   push;
   logic                         pop;
   logic [uecr_pkg::TIME_W-1:0]  q_data;
   uecr_pkg::rsp_type            rsp_out;
   logic                         partial_rsp;
   logic                         partial_ok;
   logic                         sweep_rsp;
   logic                         sweep_ok;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            uecr_pkg::CSR_CLUSTER_DIST: cfg_in.cluster_dist = csr_wdata;
            uecr_pkg::CSR_FALLBACK:     cfg_in.fallback     = csr_wdata;
            uecr_pkg::CSR_PULSE_TOP:
               cfg_in.pulse_top   = csr_wdata[uecr_pkg::SERVO_W-1:0];
            uecr_pkg::CSR_PULSE_FLOOR:
               cfg_in.pulse_floor = csr_wdata[uecr_pkg::SERVO_W-1:0];
            uecr_pkg::CSR_SERVO_STEP:
               cfg_in.servo_step  = csr_wdata[uecr_pkg::STEP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= uecr_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   uecr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push)
   );

   uecr_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .status  (q_status),
      .rd_data (q_data)
   );

   uecr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .q_data     (q_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_out    (rsp_out)
   );

   assign rsp_tuser = rsp_out.point;
   assign rsp_tdata = {{uecr_pkg::RSP_PAD_W{1'b0}}, rsp_out.done, rsp_out.servo,
                       rsp_out.range, rsp_out.trig};

   assign partial_rsp = rsp_tvalid && !rsp_out.point;
   assign partial_ok  = rsp_out.trig && (rsp_out.range == '0) && !rsp_out.done;
   assign sweep_rsp   = rsp_tvalid && rsp_out.done;
   assign sweep_ok    = rsp_out.point && !rsp_out.trig &&
                        (rsp_out.servo == cfg_ff.pulse_top);

   `UECR_ASSERT(a_partial_result, partial_rsp |-> partial_ok, "partial result with point data")
   `UECR_ASSERT(a_sweep_end, sweep_rsp |-> sweep_ok, "sweep end without servo return")
   `UECR_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_tvalid, "result right after reset")

endmodule

### rtl/core/uecr_front.sv
// Front end: accepts echo edges, keeps the start tick and turns each
// falling edge into a saturated echo time for the queue. Uses uecr_pkg.
module uecr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,   // [0] edge_level
   input  logic [uecr_pkg::REQ_DATA_W-1:0]   req_tdata,   // [31:0] edge_tick
   input  uecr_pkg::queue_status_type        q_status,
   output uecr_pkg::reading_push_type        push
);

   logic [uecr_pkg::TICK_W-1:0] start_tick_ff;
   logic [uecr_pkg::TICK_W-1:0] start_tick_in;
   logic [uecr_pkg::TICK_W-1:0] elapsed;
   logic                        accept;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && !q_status.full;

   // Wraparound comes for free from the modulo 2^32 subtraction.
   assign elapsed = req_tdata[uecr_pkg::TICK_W-1:0] - start_tick_ff;

   always_comb begin
      start_tick_in = start_tick_ff;
      push.valid    = 1'b0;
      push.data     = (|elapsed[uecr_pkg::TICK_W-1:uecr_pkg::TIME_W]) ?
                      '1 : elapsed[uecr_pkg::TIME_W-1:0];
      if (accept) begin
         if (req_tuser) begin
            start_tick_in = req_tdata[uecr_pkg::TICK_W-1:0];
         end else begin
            push.valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_tick_ff <= '0;
      end else begin
         start_tick_ff <= start_tick_in;
      end
   end

endmodule

### rtl/core/uecr_fifo.sv
// Short queue of echo times between the front end and the back end.
// Uses uecr_pkg for its depth and entry types.
module uecr_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  uecr_pkg::reading_push_type    push,
   input  logic                          pop,
   output uecr_pkg::queue_status_type    status,
   output logic [uecr_pkg::TIME_W-1:0]   rd_data
);

   logic [uecr_pkg::TIME_W-1:0] mem_ff [uecr_pkg::QUEUE_DEPTH];
   logic [uecr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [uecr_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [uecr_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == uecr_pkg::QCNT_W'(uecr_pkg::QUEUE_DEPTH));
   assign rd_data      = mem_ff[rd_ptr_ff];
   assign do_push      = push.valid && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == uecr_pkg::QPTR_W'(uecr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == uecr_pkg::QPTR_W'(uecr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/uecr_back.sv
// Back end: collects echo times into groups, marks clustered readings,
// divides for the mean, scales it to millimetres and steps the servo.
// Uses uecr_pkg; pops from uecr_fifo and owns the result register.
module uecr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  uecr_pkg::cfg_type             cfg,
   input  uecr_pkg::queue_status_type    q_status,
   input  logic [uecr_pkg::TIME_W-1:0]   q_data,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output uecr_pkg::rsp_type             rsp_out
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                         state_ff, state_in;
   logic [uecr_pkg::TIME_W-1:0]       store_ff [uecr_pkg::READINGS_PER_POINT];
   logic                              store_we;
   logic [uecr_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [uecr_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [uecr_pkg::DIV_STEP_W-1:0]   step_ff, step_in;
   logic [uecr_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [uecr_pkg::CNT_W-1:0]        mcnt_ff, mcnt_in;
   logic [uecr_pkg::CNT_W-1:0]        rem_ff, rem_in;
   logic                              grp_ff, grp_in;
   logic [uecr_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [uecr_pkg::SERVO_W-1:0]      servo_ff, servo_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   uecr_pkg::rsp_type                 rsp_ff, rsp_in;

   logic [uecr_pkg::TIME_W-1:0]       cur;
   logic                              close;
   logic [uecr_pkg::CNT_W:0]          trial;
   logic                              ge;
   logic                              out_free;
   logic                              servo_low;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_out    = rsp_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The reading under scan is compared against all others in parallel.
   always_comb begin
      logic [uecr_pkg::TIME_W-1:0] diff;
      cur   = store_ff[idx_ff];
      close = 1'b0;
      for (int k = 0; k < uecr_pkg::READINGS_PER_POINT; k++) begin
         diff = (cur > store_ff[k]) ? cur - store_ff[k] : store_ff[k] - cur;
         if ((uecr_pkg::IDX_W'(k) != idx_ff) && (diff <= cfg.cluster_dist)) begin
            close = 1'b1;
         end
      end
   end

   assign trial = {rem_ff, sum_ff[uecr_pkg::SUM_W-1]};
   assign ge    = (trial >= {1'b0, mcnt_ff});

   assign servo_low = ({1'b0, servo_ff} <
                       (uecr_pkg::SERVO_CMP_W'(cfg.pulse_floor) +
                        uecr_pkg::SERVO_CMP_W'(cfg.servo_step)));

   always_comb begin
      state_in     = state_ff;
      store_we     = 1'b0;
      pop          = 1'b0;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      mcnt_in      = mcnt_ff;
      rem_in       = rem_ff;
      grp_in       = grp_ff;
      prod_in      = prod_ff;
      servo_in     = servo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               store_we = 1'b1;
               if (cnt_ff == uecr_pkg::CNT_W'(uecr_pkg::READINGS_PER_POINT - 1)) begin
                  cnt_in   = '0;
                  grp_in   = 1'b1;
                  idx_in   = '0;
                  sum_in   = '0;
                  mcnt_in  = '0;
                  state_in = ST_SCAN;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  grp_in   = 1'b0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            // A lone reading per point is its own mean.
            if (close || uecr_pkg::SINGLE_READING) begin
               sum_in  = sum_ff + uecr_pkg::SUM_W'(cur);
               mcnt_in = mcnt_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == uecr_pkg::IDX_W'(uecr_pkg::READINGS_PER_POINT - 1)) begin
               rem_in  = '0;
               step_in = '0;
               state_in = (mcnt_in == '0) ? ST_EMIT : ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            rem_in  = ge ? uecr_pkg::CNT_W'(trial - {1'b0, mcnt_ff}) :
                           trial[uecr_pkg::CNT_W-1:0];
            sum_in  = {sum_ff[uecr_pkg::SUM_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == uecr_pkg::DIV_STEP_W'(uecr_pkg::SUM_W - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = uecr_pkg::PROD_W'(sum_ff[uecr_pkg::TIME_W-1:0]) *
                       uecr_pkg::PROD_W'(uecr_pkg::RANGE_SCALE);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (grp_ff) begin
                  rsp_in.point = 1'b1;
                  rsp_in.range = (mcnt_ff != '0) ?
                                 uecr_pkg::RANGE_W'(prod_ff >> uecr_pkg::RANGE_SHIFT) :
                                 cfg.fallback;
                  if (servo_low) begin
                     servo_in    = cfg.pulse_top;
                     rsp_in.done = 1'b1;
                     rsp_in.trig = 1'b0;
                  end else begin
                     servo_in    = servo_ff - uecr_pkg::SERVO_W'(cfg.servo_step);
                     rsp_in.done = 1'b0;
                     rsp_in.trig = 1'b1;
                  end
               end else begin
                  rsp_in.point = 1'b0;
                  rsp_in.range = '0;
                  rsp_in.done  = 1'b0;
                  rsp_in.trig  = 1'b1;
               end
               rsp_in.servo = servo_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[cnt_ff[uecr_pkg::IDX_W-1:0]] <= q_data;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      step_ff <= step_in;
      sum_ff  <= sum_in;
      mcnt_ff <= mcnt_in;
      rem_ff  <= rem_in;
      grp_ff  <= grp_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         servo_ff     <= uecr_pkg::CFG_RESET.pulse_top;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         servo_ff     <= servo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
